[rtl/core/pcbd_pkg.sv]
// Shared types, register codes and constants of the plane corner deformation block.
package pcbd_pkg;

	typedef logic signed [31:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vec3_t;

	typedef enum logic [1:0] {
		FACE_X = 2'd0,
		FACE_Y = 2'd1,
		FACE_Z = 2'd2
	} orientation_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef enum logic [2:0] {
		REG_ORIENTATION = 3'd0,
		REG_CORNER_TL   = 3'd1,
		REG_CORNER_TR   = 3'd2,
		REG_CORNER_BR   = 3'd3,
		REG_CORNER_BL   = 3'd4,
		REG_LOW_U       = 3'd5,
		REG_LOW_V       = 3'd6,
		REG_INV_SIZE    = 3'd7
	} cfg_reg_t;

	// Stage enables handed to the sample coordinate multipliers.
	typedef struct packed {
		logic s2;
		logic s3;
	} smp_en_t;

	localparam int SAMPLE_W   = 20;
	localparam int SAMPLE_MAX = 524287;
	localparam int SAMPLE_MIN = -524288;
	localparam int WEIGHT_W   = 26;
	localparam int PIPE_DEPTH = 7;

	localparam coord_t      LOW_CORNER_RESET = 32'shFFFF0000;
	localparam logic [63:0] INV_SIZE_RESET   = 64'h0080_0000_0080_0000;

endpackage

[rtl/core/pcbd_vertex_if.sv]
// Input channel carrying one plane vertex per transaction.
interface pcbd_vertex_if import pcbd_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t vertex_x;
	coord_t vertex_y;
	coord_t vertex_z;

	modport source(output valid, output vertex_x, output vertex_y, output vertex_z,
		input ready);
	modport sink(input valid, input vertex_x, input vertex_y, input vertex_z,
		output ready);
endinterface

[rtl/core/pcbd_moved_if.sv]
// Output channel carrying one displaced vertex per transaction.
interface pcbd_moved_if import pcbd_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t moved_x;
	coord_t moved_y;
	coord_t moved_z;

	modport source(output valid, output moved_x, output moved_y, output moved_z,
		input ready);
	modport sink(input valid, input moved_x, input moved_y, input moved_z,
		output ready);
endinterface

[rtl/core/pcbd_sample_mul.sv]
// Two-stage sample coordinate unit: offset times reciprocal size, floored and saturated.
module pcbd_sample_mul import pcbd_pkg::*; (
	input  logic                       clk,
	input  smp_en_t                    en,
	input  logic signed [32:0]         d,
	input  logic        [31:0]         inv,
	output logic signed [SAMPLE_W-1:0] s
);

	localparam logic signed [41:0] SatHi = 42'(SAMPLE_MAX);
	localparam logic signed [41:0] SatLo = 42'(SAMPLE_MIN);

	logic signed [49:0] ph_s2;
	logic signed [49:0] pl_s2;
	logic signed [65:0] full;
	logic signed [41:0] q;
	logic signed [SAMPLE_W-1:0] s_s3;

	// The 33 by 32 bit product is taken as two 33 by 16 bit halves.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			ph_s2 <= d * $signed({1'b0, inv[31:16]});
			pl_s2 <= d * $signed({1'b0, inv[15:0]});
		end
	end

	always_comb begin
		full = $signed({ph_s2, 16'b0}) + 66'(pl_s2);
		q    = full[65:24];
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			if (q > SatHi) begin
				s_s3 <= SatHi[SAMPLE_W-1:0];
			end else if (q < SatLo) begin
				s_s3 <= SatLo[SAMPLE_W-1:0];
			end else begin
				s_s3 <= q[SAMPLE_W-1:0];
			end
		end
	end

	assign s = s_s3;

endmodule

[rtl/core/plane_corner_bilinear_deform.sv]
// Top level of the plane corner deformation block.
// Each vertex is moved along the plane's normal axis by the bilinear blend of the four corner
// displacements, sampled at the vertex position relative to the plane's low corner. The block
// is a seven-stage pipeline that accepts one vertex per cycle while the output is not stalled;
// each vertex passes through axis selection, the two-stage split product of offset and reciprocal size,
// the weight products, the corner products and a two-stage saturating sum. A stall at the output
// holds every stage that is occupied, and empty stages still fill, so input is refused only while
// the whole pipeline is full and stalled. Configuration is to be written while no vertex is in
// flight.
module plane_corner_bilinear_deform import pcbd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	pcbd_vertex_if.sink   vertex,
	pcbd_moved_if.source  moved,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [63:0]   cfg_data
);

	localparam logic signed [44:0] ResHi = 45'sd2147483647;
	localparam logic signed [44:0] ResLo = -45'sd2147483648;

	// Configuration registers.
	logic [1:0]  orient_q;
	coord_t      corner_q [4];
	coord_t      low_u_q;
	coord_t      low_v_q;
	logic [63:0] inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q <= FACE_Y;
			for (int k = 0; k < 4; k++) begin
				corner_q[k] <= '0;
			end
			low_u_q <= LOW_CORNER_RESET;
			low_v_q <= LOW_CORNER_RESET;
			inv_q   <= INV_SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ORIENTATION: orient_q    <= cfg_data[1:0];
				REG_CORNER_TL:   corner_q[0] <= cfg_data[31:0];
				REG_CORNER_TR:   corner_q[1] <= cfg_data[31:0];
				REG_CORNER_BR:   corner_q[2] <= cfg_data[31:0];
				REG_CORNER_BL:   corner_q[3] <= cfg_data[31:0];
				REG_LOW_U:       low_u_q     <= cfg_data[31:0];
				REG_LOW_V:       low_v_q     <= cfg_data[31:0];
				REG_INV_SIZE:    inv_q       <= cfg_data;
			endcase
		end
	end

	// Valid bits and stage enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

	always_comb begin
		en_s7 = !v_s7 || moved.ready;
		en_s6 = !v_s6 || en_s7;
		en_s5 = !v_s5 || en_s6;
		en_s4 = !v_s4 || en_s5;
		en_s3 = !v_s3 || en_s4;
		en_s2 = !v_s2 || en_s3;
		en_s1 = !v_s1 || en_s2;
	end

	assign vertex.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= vertex.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	// Stage 1: pick the sample and normal axes and form the offsets from the low corner.
	vec3_t              vin;
	coord_t             vu, vv;
	logic               neg_u, neg_v;
	axis_t              axis_sel;
	logic signed [32:0] du_raw, dv_raw;

	assign vin = '{x: vertex.vertex_x, y: vertex.vertex_y, z: vertex.vertex_z};

	always_comb begin
		unique case (orientation_t'(orient_q))
			FACE_X: begin
				vu = vin.z; vv = vin.y; neg_u = 1'b1; neg_v = 1'b1; axis_sel = AXIS_X;
			end
			FACE_Z: begin
				vu = vin.x; vv = vin.y; neg_u = 1'b0; neg_v = 1'b1; axis_sel = AXIS_Z;
			end
			default: begin
				vu = vin.x; vv = vin.z; neg_u = 1'b0; neg_v = 1'b0; axis_sel = AXIS_Y;
			end
		endcase
		du_raw = 33'(vu) - 33'(low_u_q);
		dv_raw = 33'(vv) - 33'(low_v_q);
	end

	vec3_t              vtx_s1, vtx_s2, vtx_s3, vtx_s4, vtx_s5, vtx_s6;
	axis_t              axis_s1, axis_s2, axis_s3, axis_s4, axis_s5, axis_s6;
	logic signed [32:0] du_s1, dv_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			vtx_s1  <= vin;
			axis_s1 <= axis_sel;
			du_s1   <= neg_u ? -du_raw : du_raw;
			dv_s1   <= neg_v ? -dv_raw : dv_raw;
		end
		if (en_s2) begin vtx_s2 <= vtx_s1; axis_s2 <= axis_s1; end
		if (en_s3) begin vtx_s3 <= vtx_s2; axis_s3 <= axis_s2; end
		if (en_s4) begin vtx_s4 <= vtx_s3; axis_s4 <= axis_s3; end
		if (en_s5) begin vtx_s5 <= vtx_s4; axis_s5 <= axis_s4; end
		if (en_s6) begin vtx_s6 <= vtx_s5; axis_s6 <= axis_s5; end
	end

	// Stages 2 and 3: sample coordinates.
	smp_en_t                    smp_en;
	logic signed [SAMPLE_W-1:0] su_s3, sv_s3;

	assign smp_en = '{s2: en_s2, s3: en_s3};

	pcbd_sample_mul u_sample_u (
		.clk (clk),
		.en  (smp_en),
		.d   (du_s1),
		.inv (inv_q[63:32]),
		.s   (su_s3)
	);

	pcbd_sample_mul u_sample_v (
		.clk (clk),
		.en  (smp_en),
		.d   (dv_s1),
		.inv (inv_q[31:0]),
		.s   (sv_s3)
	);

	// Stage 4: bilinear weights in the corner order top-left, top-right, bottom-right,
	// bottom-left.
	logic signed [20:0]         su21, sv21, ou, ov;
	logic signed [41:0]         wprod [4];
	logic signed [WEIGHT_W-1:0] w_s4  [4];

	always_comb begin
		su21     = 21'(su_s3);
		sv21     = 21'(sv_s3);
		ou       = 21'sd65536 - su21;
		ov       = 21'sd65536 - sv21;
		wprod[0] = ou * ov;
		wprod[1] = su21 * ov;
		wprod[2] = su21 * sv21;
		wprod[3] = ou * sv21;
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int k = 0; k < 4; k++) begin
				w_s4[k] <= wprod[k][41:16];
			end
		end
	end

	// Stage 5: corner products.
	logic signed [57:0] p_s5 [4];

	always_ff @(posedge clk) begin
		if (en_s5) begin
			for (int k = 0; k < 4; k++) begin
				p_s5[k] <= corner_q[k] * w_s4[k];
			end
		end
	end

	// Stage 6: pairwise sums.
	logic signed [58:0] pa_s6, pb_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			pa_s6 <= 59'(p_s5[0]) + 59'(p_s5[1]);
			pb_s6 <= 59'(p_s5[2]) + 59'(p_s5[3]);
		end
	end

	// Stage 7: final sum, added to the normal coordinate with saturation.
	logic signed [59:0] total;
	logic signed [43:0] deform;
	coord_t             vn, vn_new;
	logic signed [44:0] res;
	vec3_t              vout;
	vec3_t              out_s7;

	always_comb begin
		total  = 60'(pa_s6) + 60'(pb_s6);
		deform = total[59:16];
		unique case (axis_s6)
			AXIS_X:  vn = vtx_s6.x;
			AXIS_Z:  vn = vtx_s6.z;
			default: vn = vtx_s6.y;
		endcase
		res = 45'(vn) + 45'(deform);
		if (res > ResHi) begin
			vn_new = ResHi[31:0];
		end else if (res < ResLo) begin
			vn_new = ResLo[31:0];
		end else begin
			vn_new = res[31:0];
		end
		vout = vtx_s6;
		unique case (axis_s6)
			AXIS_X:  vout.x = vn_new;
			AXIS_Z:  vout.z = vn_new;
			default: vout.y = vn_new;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			out_s7 <= vout;
		end
	end

	assign moved.valid   = v_s7;
	assign moved.moved_x = out_s7.x;
	assign moved.moved_y = out_s7.y;
	assign moved.moved_z = out_s7.z;

endmodule

[rtl/core/pcbd_checker.sv]
// Port-level checks of the plane corner deformation block, bound to its top level.
module pcbd_checker import pcbd_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_ready,
	input logic   out_valid,
	input logic   out_ready,
	input coord_t moved_x,
	input coord_t moved_y,
	input coord_t moved_z
);

	logic [3:0] inflight_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + 4'd1;
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - 4'd1;
		end
	end

	// A result never appears without a transaction having entered for it.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 4'd0 |-> !out_valid)
		else $error("result offered with no vertex in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 4'(PIPE_DEPTH))
		else $error("more vertices in flight than pipeline stages");

	// With nothing waiting at the output every stage can move, so input is never refused.
	a_ready_when_empty_out: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused while output stage is empty");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped during a stall");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(moved_x) && $stable(moved_y) && $stable(moved_z))
		else $error("output payload changed during a stall");

endmodule

bind plane_corner_bilinear_deform pcbd_checker u_pcbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (vertex.valid),
	.in_ready  (vertex.ready),
	.out_valid (moved.valid),
	.out_ready (moved.ready),
	.moved_x   (moved.moved_x),
	.moved_y   (moved.moved_y),
	.moved_z   (moved.moved_z)
);
